[rtl/urdf_pkg.sv]
// Shared types, codes and the CRC-8 byte step for the UART register datagram framer.
// Used by urdf_reply_rx, urdf_frame_tx and uart_register_datagram_framer.
package urdf_pkg;

  // Operation codes carried in s_tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  // Reply status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_PRE_ERR = 2'd2;
  localparam logic [1:0] ST_REG_ERR = 2'd3;

  // Register indexes of the configuration port
  localparam logic REG_SYNC   = 1'b0;
  localparam logic REG_MASTER = 1'b1;

  // Header constants
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [3:0] SYNC_RESET   = 4'd5;
  localparam logic [7:0] MASTER_RESET = 8'hFF;

  // Frame geometry
  localparam int unsigned WRITE_LEN = 8;
  localparam int unsigned READ_LEN  = 4;
  localparam int unsigned REPLY_LEN = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned BODY_W    = 8 * (WRITE_LEN - 1);

  // Output item kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  // One job handed to the transmitter: a frame body or a reply result
  typedef struct packed {
    logic              kind;
    logic [CNT_W-1:0]  nbytes;
    logic [BODY_W-1:0] body;
    logic [1:0]        status;
    logic [31:0]       rdata;
  } tx_job_t;

  // Outcome of one reply byte
  typedef struct packed {
    logic        done;
    logic [1:0]  status;
    logic [31:0] rdata;
  } rx_result_t;

  // Feed one byte into the CRC, data bits least significant first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = data_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[7] ^ d[0];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

[rtl/uart_register_datagram_framer.sv]
// UART register datagram framer/deframer with CRC-8 (poly 0x07, LSB-first data).
// m_tvalid is registered: an input transfer loads the transmit sequencer, which then
// fills its output register. A write frame has 8 bytes and a read frame 4, CRC included;
// each goes out a byte per cycle unless m_tready stalls; new input waits for its last byte.
// Reset (rst, synchronous): sync 5, master address 0xFF, reply state cleared.
// Depends on urdf_pkg, urdf_reply_rx and urdf_frame_tx.
module uart_register_datagram_framer
  import urdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Command/reply input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // dev_addr[1:0], reg_req[8:2], value[40:9], rx_byte[48:41]
  input  logic [1:0]  s_tuser,   // op[1:0]
  // Frame/result output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // tx_byte[7:0], status[9:8], read_value[41:10]
  output logic        m_tuser,   // kind[0]
  output logic        m_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]  sync_pattern;
  logic [7:0]  master_address;
  logic        cfg_write;

  logic [1:0]  op;
  logic [1:0]  dev_addr;
  logic [6:0]  reg_req;
  logic [31:0] value;
  logic [7:0]  rx_byte;
  logic        accept;
  logic        reply_byte;
  logic        tx_free;
  logic        tx_load;
  tx_job_t     job;
  rx_result_t  rx_res;

  logic [7:0]  out_byte;
  logic [1:0]  out_status;
  logic [31:0] out_rdata;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern   <= SYNC_RESET;
      master_address <= MASTER_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SYNC) begin
        sync_pattern <= pwdata[3:0];
      end else begin
        master_address <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MASTER) ? {24'h0, master_address}
                                           : {28'h0, sync_pattern};

  // Unpack the input transfer
  assign op         = s_tuser;
  assign dev_addr   = s_tdata[1:0];
  assign reg_req    = s_tdata[8:2];
  assign value      = s_tdata[40:9];
  assign rx_byte    = s_tdata[48:41];

  assign s_tready   = tx_free;
  assign accept     = s_tvalid && s_tready;
  assign reply_byte = accept && (op == OP_REPLY);

  // Build the job for the transmit sequencer
  always_comb begin
    job.kind          = KIND_TX;
    job.nbytes        = CNT_W'(WRITE_LEN);
    job.body          = '0;
    job.body[7:0]     = {4'h0, sync_pattern};
    job.body[15:8]    = {6'h00, dev_addr};
    job.body[23:16]   = {1'b0, reg_req};
    job.status        = rx_res.status;
    job.rdata         = rx_res.rdata;
    tx_load           = 1'b0;
    unique case (op)
      OP_WRITE: begin
        job.body[23:16] = {1'b0, reg_req} | WRITE_FLAG;
        job.body[31:24] = value[31:24];
        job.body[39:32] = value[23:16];
        job.body[47:40] = value[15:8];
        job.body[55:48] = value[7:0];
        tx_load         = accept;
      end
      OP_READ: begin
        job.nbytes = CNT_W'(READ_LEN);
        tx_load    = accept;
      end
      OP_REPLY: begin
        job.kind   = KIND_RESULT;
        job.nbytes = CNT_W'(1);
        tx_load    = accept && rx_res.done;
      end
      default: begin
        tx_load = 1'b0;
      end
    endcase
  end

  urdf_reply_rx u_reply_rx (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (reply_byte),
    .rx_byte        (rx_byte),
    .reg_req        (reg_req),
    .sync_pattern   (sync_pattern),
    .master_address (master_address),
    .result         (rx_res)
  );

  urdf_frame_tx u_frame_tx (
    .clk        (clk),
    .rst        (rst),
    .load       (tx_load),
    .job        (job),
    .free       (tx_free),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_byte   (out_byte),
    .out_last   (m_tlast),
    .out_status (out_status),
    .out_rdata  (out_rdata)
  );

  // Pack the output transfer
  assign m_tdata = {6'h00, out_rdata, out_status, out_byte};

endmodule

[rtl/urdf_reply_rx.sv]
// Reply deframer: checks eight reply bytes one at a time and reports the outcome.
// Depends on urdf_pkg.
module urdf_reply_rx
  import urdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  input  logic [6:0] reg_req,
  input  logic [3:0] sync_pattern,
  input  logic [7:0] master_address,
  output rx_result_t result
);

  logic [2:0]  reply_count;
  logic [7:0]  reply_crc;
  logic        preamble_good;
  logic        register_good;
  logic [31:0] reply_data;
  logic        final_byte;

  assign final_byte = (reply_count == 3'(REPLY_LEN - 1));

  // Judge the reply on its CRC byte, checks in priority order
  always_comb begin
    result.done   = final_byte;
    result.status = ST_OK;
    result.rdata  = '0;
    priority if (rx_byte != reply_crc) begin
      result.status = ST_CRC_ERR;
    end else if (!preamble_good) begin
      result.status = ST_PRE_ERR;
    end else if (!register_good) begin
      result.status = ST_REG_ERR;
    end else begin
      result.rdata = reply_data;
    end
  end

  // Advance the reply state on each byte, clear it after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_count   <= '0;
      reply_crc     <= '0;
      preamble_good <= 1'b1;
      register_good <= 1'b1;
    end else if (byte_valid) begin
      if (final_byte) begin
        reply_count   <= '0;
        reply_crc     <= '0;
        preamble_good <= 1'b1;
        register_good <= 1'b1;
      end else begin
        reply_crc   <= crc8_feed(reply_crc, rx_byte);
        reply_count <= reply_count + 3'd1;
        if (reply_count == 3'd0 && rx_byte[3:0] != sync_pattern) begin
          preamble_good <= 1'b0;
        end
        if (reply_count == 3'd1 && rx_byte != master_address) begin
          preamble_good <= 1'b0;
        end
        if (reply_count == 3'd2 && rx_byte[6:0] != reg_req) begin
          register_good <= 1'b0;
        end
      end
    end
  end

  // Gather data bytes, most significant first
  always_ff @(posedge clk) begin
    if (byte_valid && reply_count >= 3'd3 && !final_byte) begin
      reply_data <= {reply_data[23:0], rx_byte};
    end
  end

endmodule

[rtl/urdf_frame_tx.sv]
// Transmit sequencer: sends a frame one byte a cycle unless stalled, then its CRC,
// or one reply result; holds each item in an output register. Depends on urdf_pkg.
module urdf_frame_tx
  import urdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  tx_job_t     job,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic [31:0] out_rdata
);

  logic [CNT_W-1:0]  rem;
  logic              kind;
  logic [BODY_W-1:0] body;
  logic [7:0]        crc;
  logic [1:0]        status;
  logic [31:0]       rdata;
  logic              emit;
  logic              tail;
  logic [7:0]        byte_next;

  assign tail = (rem == CNT_W'(1));
  assign emit = (rem != '0) && (!out_valid || out_ready);
  assign free = (rem == '0) || (tail && emit);

  // Pick the byte to send: body bytes, then the CRC
  assign byte_next = tail ? crc : body[7:0];

  // Load a job or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= job.nbytes;
    end else if (emit) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind   <= job.kind;
      body   <= job.body;
      crc    <= '0;
      status <= job.status;
      rdata  <= job.rdata;
    end else if (emit) begin
      body <= {8'h00, body[BODY_W-1:8]};
      crc  <= crc8_feed(crc, body[7:0]);
    end
  end

  // Output register: fill on emit, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= kind;
      if (kind == KIND_RESULT) begin
        out_byte   <= '0;
        out_last   <= 1'b0;
        out_status <= status;
        out_rdata  <= rdata;
      end else begin
        out_byte   <= byte_next;
        out_last   <= tail;
        out_status <= ST_OK;
        out_rdata  <= '0;
      end
    end
  end

endmodule
